// ===== src/stack_with_middle_ops_unit_assert.svh =====
// Assertion macros shared by the stack design
`ifndef STACK_WITH_MIDDLE_OPS_UNIT_ASSERT_SVH
`define STACK_WITH_MIDDLE_OPS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger
`define ASSERT_SAME(label, clk, rstn, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rstn, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/swmo_pkg.sv =====
package swmo_pkg;

    localparam int unsigned DEPTH   = 64;
    localparam int unsigned AW      = $clog2(DEPTH);
    localparam int unsigned CW      = $clog2(DEPTH + 1);
    localparam int unsigned FILL_W  = 7;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Result bundle from the stack engine to the output stage
    typedef struct packed {
        logic [31:0]       read_value;
        status_t           status;
        logic [FILL_W-1:0] fill_count;
    } result_t;

endpackage

// ===== src/swmo_engine.sv =====
// Stack engine: one synchronous memory, one command at a time
module swmo_engine
    import swmo_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  cmd_t        cmd,
    input  logic [31:0] push_value,
    output logic        busy,
    output logic        done,
    output result_t     result
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    cmd_t               cmd_reg, cmd_next;
    logic [31:0]        rdval_reg, rdval_next;
    status_t            st_reg, st_next;

    logic [31:0]        mem [DEPTH];
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;

    // Storage, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;
        rdval_next = rdval_reg;
        st_next    = st_reg;
        rd_addr    = idx_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = push_value;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cmd_next   = cmd;
                    rdval_next = '0;
                    st_next    = ST_OK;
                    state_next = S_DONE;
                    case (cmd)
                        CMD_PUSH: begin
                            if (count_reg >= CW'(DEPTH)) begin
                                st_next = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                st_next = ST_EMPTY;
                                if (cmd != CMD_DELETE) begin
                                    rdval_next = '1;
                                end
                            end else if (cmd == CMD_POP) begin
                                idx_next   = count_reg - 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = S_READ;
                            end else if (cmd == CMD_FIND) begin
                                idx_next   = count_reg >> 1;
                                state_next = S_READ;
                            end else begin
                                // Close the gap: copy each entry above the middle down
                                idx_next = count_reg >> 1;
                                if ((count_reg >> 1) + 1'b1 < count_reg) begin
                                    state_next = S_SHIFT;
                                end
                                count_next = count_reg - 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                state_next = S_WRITE;
            end
            S_SHIFT: begin
                // Fetch the entry above the current hole
                rd_addr    = AW'(idx_reg + 1'b1);
                state_next = S_WRITE;
            end
            S_WRITE: begin
                if (cmd_reg == CMD_DELETE) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    idx_next = idx_reg + 1'b1;
                    // count already decremented: last hole index is count_reg - 1
                    state_next = (idx_reg + 1'b1 < count_reg) ? S_SHIFT : S_DONE;
                end else begin
                    rdval_next = rd_data;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg   <= idx_next;
        cmd_reg   <= cmd_next;
        rdval_reg <= rdval_next;
        st_reg    <= st_next;
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = (state_reg == S_DONE);
    assign result.read_value = rdval_reg;
    assign result.status     = st_reg;
    assign result.fill_count = FILL_W'(count_reg);

endmodule

// ===== src/stack_with_middle_ops_unit.sv =====
// Bounded stack of 64 signed words with push, pop, find-middle and
// delete-middle. s_tdata = {push_value, cmd}; m_tdata = {fill_count, status,
// read_value}. One command at a time: s_tready stays low from a transfer in
// until its result has left on the master side. For a push, for any empty or
// full case and for a delete with nothing to move, the engine goes straight to
// its done state; pop and find pass through a read and a write state (one
// memory read through the registered port). A delete-middle passes through a
// shift and a write state for each entry moved down, since the single memory
// copies one word at a time through its registered read port. The result is
// then offered from the output register.
module stack_with_middle_ops_unit
    import swmo_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] cmd, [33:2] push_value, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [31:0] read_value, [33:32] status, [40:34] fill_count
);

`include "stack_with_middle_ops_unit_assert.svh"

    logic    busy, done;
    result_t result;
    result_t out_reg;
    logic    mvalid_reg;
    logic    start;

    assign s_tready = !busy && !mvalid_reg;
    assign start    = s_tvalid && s_tready;

    swmo_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .cmd        (cmd_t'(s_tdata[1:0])),
        .push_value (s_tdata[33:2]),
        .busy       (busy),
        .done       (done),
        .result     (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (done) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
        if (done) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'd0, out_reg.fill_count, out_reg.status, out_reg.read_value};

    `ASSERT_SAME(a_no_accept_busy, aclk, aresetn, busy, !s_tready, "accepted while busy")
    `ASSERT_NEXT(a_done_valid, aclk, aresetn, done, m_tvalid, "result lost")
    `ASSERT_SAME(a_fill_range, aclk, aresetn, m_tvalid, m_tdata[40:34] <= 7'(DEPTH),
        "fill count out of range")

endmodule

// ===== test/tb.sv =====
module tb;
    import swmo_pkg::*;

    localparam int N_RANDOM = 1480;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    typedef struct {
        cmd_t        op;
        logic [31:0] word;
        bit          typed;   // expected result written into the row
        logic [31:0] rd;
        status_t     st;
        logic [6:0]  fill;
    } row_t;

    // Same bit order as m_tdata[40:0]
    typedef struct packed {
        logic [6:0]  fill;
        status_t     st;
        logic [31:0] rd;
    } outcome_t;

    // Predictor state
    logic [31:0] stack_mem [DEPTH];
    int unsigned stack_cnt;
    outcome_t    pending_q[$];

    int errors = 0;
    int idle_pct_s = 0;
    int idle_pct_m = 0;
    bit hold_off = 1'b0;

    stack_with_middle_ops_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    // Stack behaviour for one command
    function automatic outcome_t stack_apply(cmd_t op, logic [31:0] word);
        outcome_t r;
        r.rd = '0;
        r.st = ST_OK;
        case (op)
            CMD_PUSH: begin
                if (stack_cnt >= DEPTH) begin
                    r.st = ST_FULL;
                end else begin
                    stack_mem[stack_cnt] = word;
                    stack_cnt++;
                end
            end
            CMD_POP: begin
                if (stack_cnt == 0) begin
                    r.rd = '1;
                    r.st = ST_EMPTY;
                end else begin
                    stack_cnt--;
                    r.rd = stack_mem[stack_cnt];
                end
            end
            CMD_FIND: begin
                if (stack_cnt == 0) begin
                    r.rd = '1;
                    r.st = ST_EMPTY;
                end else begin
                    r.rd = stack_mem[stack_cnt/2];
                end
            end
            default: begin
                if (stack_cnt == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    for (int i = stack_cnt/2; i + 1 < stack_cnt; i++)
                        stack_mem[i] = stack_mem[i+1];
                    stack_cnt--;
                end
            end
        endcase
        r.fill = stack_cnt[6:0];
        return r;
    endfunction

    // Offer one command and wait for its transfer; tvalid drops only while idling
    task automatic send_cmd(cmd_t op, logic [31:0] word);
        while ($urandom_range(99) < idle_pct_s) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, word, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_checked(cmd_t op, logic [31:0] word);
        pending_q.push_back(stack_apply(op, word));
        send_cmd(op, word);
    endtask

    // Receiver: random stalls, optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= idle_pct_m);
    end

    // Result checking against the oldest expectation
    always @(posedge aclk) begin
        outcome_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[40:0];
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_q.pop_front();
                if (got.rd !== want.rd || got.st !== want.st || got.fill !== want.fill) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp rd=%h st=%0d fill=%0d, got rd=%h st=%0d fill=%0d",
                                 want.rd, want.st, want.fill, got.rd, got.st, got.fill);
                end
            end
        end
    end

    // Random command, pushes up to half the time while shallow, more pops when deep
    task automatic send_random();
        int unsigned p;
        logic [31:0] w;
        cmd_t op;
        p = $urandom_range(99);
        w = $urandom;
        if (p < 50 - stack_cnt / 2) op = CMD_PUSH;
        else if (p < 70) op = CMD_POP;
        else if (p < 85) op = CMD_FIND;
        else op = CMD_DELETE;
        send_checked(op, w);
    endtask

    initial begin
        row_t rows[$];
        outcome_t r;
        int wait_cyc;
        // Directed rows: empty cases, extremes, odd/even middles, fill
        rows = '{
            '{CMD_POP,    32'h0,        1, 32'hFFFF_FFFF, ST_EMPTY, 7'd0},
            '{CMD_FIND,   32'h0,        1, 32'hFFFF_FFFF, ST_EMPTY, 7'd0},
            '{CMD_DELETE, 32'h0,        1, 32'h0,         ST_EMPTY, 7'd0},
            '{CMD_PUSH,   32'h8000_0000,1, 32'h0,         ST_OK,    7'd1},
            '{CMD_FIND,   32'h0,        0, 0, ST_OK, 0},
            '{CMD_PUSH,   32'h7FFF_FFFF,1, 32'h0,         ST_OK,    7'd2},
            '{CMD_PUSH,   32'hFFFF_FFFF,0, 0, ST_OK, 0},
            '{CMD_PUSH,   32'h0,        0, 0, ST_OK, 0},
            '{CMD_FIND,   32'h0,        0, 0, ST_OK, 0},
            '{CMD_DELETE, 32'h0,        0, 0, ST_OK, 0},
            '{CMD_FIND,   32'h0,        0, 0, ST_OK, 0},
            '{CMD_DELETE, 32'h0,        0, 0, ST_OK, 0},
            '{CMD_POP,    32'h0,        0, 0, ST_OK, 0},
            '{CMD_POP,    32'h0,        0, 0, ST_OK, 0},
            '{CMD_PUSH,   32'h5555_AAAA,0, 0, ST_OK, 0},
            '{CMD_DELETE, 32'h0,        1, 32'h0,         ST_OK,    7'd0},
            '{CMD_POP,    32'h0,        1, 32'hFFFF_FFFF, ST_EMPTY, 7'd0}
        };
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        stack_cnt = 0;
        @(posedge aclk);

        foreach (rows[k]) begin
            r = stack_apply(rows[k].op, rows[k].word);
            if (rows[k].typed) begin
                r.rd = rows[k].rd;
                r.st = rows[k].st;
                r.fill = rows[k].fill;
            end
            pending_q.push_back(r);
            send_cmd(rows[k].op, rows[k].word);
        end

        // Fill to the top, push into a full stack, then drain partly via delete
        for (int i = 0; i < DEPTH + 3; i++) send_checked(CMD_PUSH, $urandom);
        send_checked(CMD_FIND, 0);
        for (int i = 0; i < DEPTH / 2; i++) send_checked(CMD_DELETE, 0);

        // Back pressure: receiver holds off while commands keep coming
        hold_off = 1'b1;
        fork
            begin
                for (int i = 0; i < 20; i++) send_random();
            end
            begin
                wait_cyc = 0;
                while (wait_cyc < 300) begin
                    @(posedge aclk);
                    wait_cyc++;
                end
                hold_off = 1'b0;
            end
        join

        // Random phases with different idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct_s = 0;  idle_pct_m = 0;  end
                1: begin idle_pct_s = 67; idle_pct_m = 0;  end
                2: begin idle_pct_s = 0;  idle_pct_m = 67; end
                default: begin idle_pct_s = 38; idle_pct_m = 38; end
            endcase
            for (int i = 0; i < N_RANDOM / 4; i++) send_random();
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== stack_with_middle_ops_unit.f =====
+incdir+src
src/swmo_pkg.sv
src/swmo_engine.sv
src/stack_with_middle_ops_unit.sv
test/tb.sv
